[hw/rtl/modexp_pkg.sv]
// Package for the modular exponentiation block: sequencer phase codes.
// No dependencies.
`default_nettype none
package modexp_pkg;
  localparam int PhaseBits = 3;
  typedef logic [PhaseBits-1:0] phase_t;
  localparam phase_t PH_IDLE = 3'd0;
  localparam phase_t PH_RED  = 3'd1;  // reduce base mod m, one bit a cycle
  localparam phase_t PH_MUL  = 3'd2;  // prod = prod*b mod m, bit serial
  localparam phase_t PH_SQR  = 3'd3;  // b = b*b mod m, bit serial
  localparam phase_t PH_OUT  = 3'd4;
endpackage
`default_nettype wire

[hw/rtl/modexp_if.sv]
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
`default_nettype none
interface modexp_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/modular_exponentiation.sv]
// Top level of the modular exponentiation block: right-to-left binary
// exponentiation with a bit-serial shift-and-add modular multiplier.
// Depends on modexp_pkg and modexp_if.
//
//  channel | dir | payload {msb..lsb}
//  in_     | in  | {modulus_value, power, base_value}
//  out_    | out | {bad_modulus, residue}
//
// An item first reduces the base mod m, bit by bit. Then, for each exponent
// bit up to the highest set one, it runs the multiply when the bit is set,
// and a squaring for every bit below the highest set one. Zero modulus and
// zero exponent go straight from the accept step to the output step.
// Reset is synchronous.
// A stalled result holds in the output register. The next item is accepted
// and computed, then waits at the output step until the held result leaves.
`default_nettype none
module modular_exponentiation #(
  parameter int OPERAND_BITS = 31
) (
  input  wire logic clk,
  input  wire logic rst_n,
  modexp_if.sink   in_ch,
  modexp_if.source out_ch
);
  import modexp_pkg::*;
  localparam int N  = OPERAND_BITS;
  localparam int CW = $clog2(N + 1);

  phase_t        phase_r;
  logic [N-1:0]  m_r, e_r, b_r, prod_r, acc_r, sa_r, sb_r, res_r;
  logic [N-1:0]  raw_r;          // base bits still to shift into reduction
  logic [N-1:0]  ans_r;          // finished residue, waiting for the output step
  logic [CW-1:0] cnt_r;
  logic          bad_r, ans_bad_r, valid_r;

  assign in_ch.ready  = (phase_r == PH_IDLE);
  assign out_ch.valid = valid_r;
  assign out_ch.data  = {bad_r, res_r};

  // (x + y) mod m with x, y < m; one extra bit holds the carry
  function automatic logic [N-1:0] addm(input logic [N-1:0] x, y, mm);
    logic [N:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, mm}) s = s - {1'b0, mm};
    return s[N-1:0];
  endfunction

  logic [N-1:0] red_sh;
  logic [N:0]   red_w;
  assign red_w  = {b_r, raw_r[N-1]};
  assign red_sh = (red_w >= {1'b0, m_r}) ? N'(red_w - {1'b0, m_r}) : red_w[N-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      valid_r <= 1'b0;
    end else begin
      // load the output register once the previous result has left
      if (phase_r == PH_OUT && (!valid_r || out_ch.ready)) begin
        valid_r <= 1'b1;
        res_r   <= ans_r;
        bad_r   <= ans_bad_r;
      end else if (out_ch.valid && out_ch.ready) begin
        valid_r <= 1'b0;
      end
      case (phase_r)
        PH_IDLE: if (in_ch.valid) begin
          m_r   <= in_ch.data[3*N-1:2*N];
          e_r   <= in_ch.data[2*N-1:N];
          raw_r <= in_ch.data[N-1:0];
          b_r   <= '0;
          cnt_r <= '0;
          // 1 mod m is 0 only when m is one
          prod_r <= (in_ch.data[3*N-1:2*N] == N'(1)) ? '0 : N'(1);
          if (in_ch.data[3*N-1:2*N] == '0) begin
            ans_bad_r <= 1'b1; ans_r <= '0; phase_r <= PH_OUT;
          end else if (in_ch.data[2*N-1:N] == '0) begin
            ans_bad_r <= 1'b0; ans_r <= N'(1); phase_r <= PH_OUT;
          end else begin
            ans_bad_r <= 1'b0;
            phase_r <= PH_RED;
          end
        end
        PH_RED: begin
          // restoring remainder, one base bit per cycle
          b_r   <= red_sh;
          raw_r <= raw_r << 1;
          if (cnt_r == CW'(N-1)) begin
            cnt_r <= '0;
            acc_r <= '0;
            sb_r  <= red_sh;
            if (e_r[0]) begin
              phase_r <= PH_MUL; sa_r <= prod_r;
            end else begin
              phase_r <= PH_SQR; sa_r <= red_sh;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        PH_MUL, PH_SQR: begin
          if (sb_r == '0 || cnt_r == CW'(N)) begin
            cnt_r <= '0;
            acc_r <= '0;
            if (phase_r == PH_MUL) begin
              prod_r <= acc_r;
              if (e_r[N-1:1] == '0) begin
                ans_r <= acc_r; phase_r <= PH_OUT;
              end else begin
                phase_r <= PH_SQR; sa_r <= b_r; sb_r <= b_r;
              end
            end else begin
              b_r <= acc_r;
              e_r <= e_r >> 1;
              if (e_r[1]) begin
                phase_r <= PH_MUL; sa_r <= prod_r; sb_r <= acc_r;
              end else begin
                phase_r <= PH_SQR; sa_r <= acc_r; sb_r <= acc_r;
              end
            end
          end else begin
            if (sb_r[0]) acc_r <= addm(acc_r, sa_r, m_r);
            sa_r  <= addm(sa_r, sa_r, m_r);
            sb_r  <= sb_r >> 1;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        PH_OUT: if (!valid_r || out_ch.ready) begin
          phase_r <= PH_IDLE;
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/modexp_check.sv]
// Port checker for modular_exponentiation, bound to the top level.
// Depends on modular_exponentiation.
`default_nettype none
module modexp_check #(
  parameter int OUT_W = 32
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [OUT_W-1:0] out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data[OUT_W-1] |-> out_data[OUT_W-2:0] == '0)
    else $error("bad modulus with nonzero residue");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after accept");
endmodule
bind modular_exponentiation modexp_check #(.OUT_W(OPERAND_BITS + 1)) u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire
